// File: rtl/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg: shared types and constants of the two-key record sorter
// Item formats, record layout and the command/status bundles that join the
// sort controller and the datapath.
// ----------------------------------------------------------------------------
package tks_pkg;

  // Capacity of the record store and the widths that follow from it
  localparam int unsigned MaxRecords = 64;
  localparam int unsigned IdxW       = $clog2(MaxRecords);
  localparam int unsigned CntW       = $clog2(MaxRecords + 1);

  // Field widths
  localparam int unsigned PKeyW = 12;
  localparam int unsigned SKeyW = 6;
  localparam int unsigned TagW  = 16;

  // Input item
  typedef struct packed {
    logic [PKeyW-1:0] primary_key;
    logic [SKeyW-1:0] secondary_key;
    logic [TagW-1:0]  record_tag;
    logic             last_item;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [PKeyW-1:0] out_primary_key;
    logic [SKeyW-1:0] out_secondary_key;
    logic [TagW-1:0]  out_record_tag;
    logic             last_result;
  } out_item_t;

  // Read address source of the record store
  typedef enum logic [1:0] {
    RdSrcI     = 2'd0,
    RdSrcJ     = 2'd1,
    RdSrcJNext = 2'd2
  } rd_src_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    store_in;   // write the incoming record if there is room
    logic    rd_en;      // issue a store read
    rd_src_e rd_src;     // address of that read
    logic    clr_i;
    logic    inc_i;
    logic    set_j;      // j = i + 1
    logic    inc_j;
    logic    load_cur;   // take read data into the held record
    logic    cmp_en;     // compare held record with read data, swap if out of order
    logic    wb_i;       // write held record back to slot i
    logic    load_out;   // move read data into the output register
    logic    clr_count;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic single;     // set holds one record
    logic j_at_end;   // j is the last slot of the set
    logic i_at_end;   // i is the last outer pass
    logic i_at_last;  // i is the last slot of the set
    logic out_free;   // output register can take an item this cycle
  } status_t;

endpackage

// File: rtl/tks_ctrl.sv
// ----------------------------------------------------------------------------
// tks_ctrl: sequencer of the two-key record sorter
// Steps through loading, the exchange sort passes and emission, issuing
// commands to the datapath.
// ----------------------------------------------------------------------------
module tks_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  input  tks_pkg::status_t status_i,
  output logic             in_stall_o,
  output tks_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StLoad,
    StSortInit,
    StRdI,
    StLdI,
    StCmp,
    StWb,
    StEmitRd,
    StEmitLd
  } state_e;

  state_e state_q, state_d;
  logic   in_accept;

  assign in_stall_o = (state_q != StLoad);
  assign in_accept  = in_valid_i && (state_q == StLoad);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_src = tks_pkg::RdSrcI;
    case (state_q)
      StLoad: begin
        if (in_accept) begin
          cmd_o.store_in = 1'b1;
          if (in_last_i) begin
            state_d = StSortInit;
          end
        end
      end
      StSortInit: begin
        cmd_o.clr_i = 1'b1;
        state_d = status_i.single ? StEmitRd : StRdI;
      end
      StRdI: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = tks_pkg::RdSrcI;
        cmd_o.set_j  = 1'b1;
        state_d = StLdI;
      end
      StLdI: begin
        cmd_o.load_cur = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_src   = tks_pkg::RdSrcJ;
        state_d = StCmp;
      end
      StCmp: begin
        cmd_o.cmp_en = 1'b1;
        if (status_i.j_at_end) begin
          state_d = StWb;
        end else begin
          // fetch the next slot while this one is compared
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = tks_pkg::RdSrcJNext;
          cmd_o.inc_j  = 1'b1;
        end
      end
      StWb: begin
        cmd_o.wb_i = 1'b1;
        if (status_i.i_at_end) begin
          cmd_o.clr_i = 1'b1;
          state_d = StEmitRd;
        end else begin
          cmd_o.inc_i = 1'b1;
          state_d = StRdI;
        end
      end
      StEmitRd: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = tks_pkg::RdSrcI;
        state_d = StEmitLd;
      end
      StEmitLd: begin
        // hold the read data until the output register frees up
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (status_i.i_at_last) begin
            cmd_o.clr_count = 1'b1;
            state_d = StLoad;
          end else begin
            cmd_o.inc_i = 1'b1;
            state_d = StEmitRd;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/tks_datapath.sv
// ----------------------------------------------------------------------------
// tks_datapath: record store, indices, comparator and output register
// Holds the record memory, the set count, the sort indices, the record held
// across an inner pass, the order register and the result register.
// ----------------------------------------------------------------------------
module tks_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tks_pkg::in_item_t   in_item_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_data_i,
  input  tks_pkg::cmd_t       cmd_i,
  input  logic                out_stall_i,
  output tks_pkg::status_t    status_o,
  output logic                out_valid_o,
  output tks_pkg::out_item_t  out_item_o
);

  typedef struct packed {
    logic [tks_pkg::PKeyW-1:0] pkey;
    logic [tks_pkg::SKeyW-1:0] skey;
    logic [tks_pkg::TagW-1:0]  tag;
  } record_t;

  // True when a (earlier slot) and b (later slot) are strictly out of order
  function automatic logic out_of_order(record_t a, record_t b, logic asc);
    logic gt;
    logic lt;
    gt = (a.pkey > b.pkey) || ((a.pkey == b.pkey) && (a.skey > b.skey));
    lt = (a.pkey < b.pkey) || ((a.pkey == b.pkey) && (a.skey < b.skey));
    return asc ? gt : lt;
  endfunction

  record_t                   mem_q [tks_pkg::MaxRecords];
  record_t                   rdata_q;
  record_t                   cur_q;
  record_t                   in_rec;
  record_t                   wdata;
  logic [tks_pkg::IdxW-1:0]  waddr;
  logic [tks_pkg::IdxW-1:0]  raddr;
  logic                      we;
  logic [tks_pkg::CntW-1:0]  count_q;
  logic [tks_pkg::IdxW-1:0]  i_q;
  logic [tks_pkg::IdxW-1:0]  j_q;
  logic                      asc_q;
  logic                      out_valid_q;
  tks_pkg::out_item_t        out_q;
  logic                      full;
  logic                      swap;

  assign in_rec = '{pkey: in_item_i.primary_key,
                    skey: in_item_i.secondary_key,
                    tag:  in_item_i.record_tag};

  assign full = (count_q == tks_pkg::CntW'(tks_pkg::MaxRecords));
  assign swap = cmd_i.cmp_en && out_of_order(cur_q, rdata_q, asc_q);

  // Status towards the controller
  assign status_o.single    = (count_q == tks_pkg::CntW'(1));
  assign status_o.j_at_end  = ((tks_pkg::CntW'(j_q) + tks_pkg::CntW'(1)) == count_q);
  assign status_o.i_at_end  = ((tks_pkg::CntW'(i_q) + tks_pkg::CntW'(2)) == count_q);
  assign status_o.i_at_last = ((tks_pkg::CntW'(i_q) + tks_pkg::CntW'(1)) == count_q);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  // Select the store write
  always_comb begin
    we    = 1'b0;
    waddr = i_q;
    wdata = cur_q;
    if (cmd_i.store_in && !full) begin
      we    = 1'b1;
      waddr = count_q[tks_pkg::IdxW-1:0];
      wdata = in_rec;
    end else if (swap) begin
      we    = 1'b1;
      waddr = j_q;
    end else if (cmd_i.wb_i) begin
      we    = 1'b1;
    end
  end

  // Select the store read address
  always_comb begin
    case (cmd_i.rd_src)
      tks_pkg::RdSrcI:     raddr = i_q;
      tks_pkg::RdSrcJ:     raddr = j_q;
      tks_pkg::RdSrcJNext: raddr = j_q + tks_pkg::IdxW'(1);
      default:             raddr = i_q;
    endcase
  end

  // Record store, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Held record: load at the start of a pass, take the read record on a swap
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cur) begin
      cur_q <= rdata_q;
    end else if (swap) begin
      cur_q <= rdata_q;
    end
  end

  // Count and indices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      if (cmd_i.clr_count) begin
        count_q <= '0;
      end else if (cmd_i.store_in && !full) begin
        count_q <= count_q + tks_pkg::CntW'(1);
      end
      if (cmd_i.clr_i) begin
        i_q <= '0;
      end else if (cmd_i.inc_i) begin
        i_q <= i_q + tks_pkg::IdxW'(1);
      end
      if (cmd_i.set_j) begin
        j_q <= i_q + tks_pkg::IdxW'(1);
      end else if (cmd_i.inc_j) begin
        j_q <= j_q + tks_pkg::IdxW'(1);
      end
    end
  end

  // Order register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asc_q <= 1'b1;
    end else if (cfg_valid_i) begin
      asc_q <= cfg_data_i;
    end
  end

  // Output register: load from the store, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.out_primary_key   <= rdata_q.pkey;
      out_q.out_secondary_key <= rdata_q.skey;
      out_q.out_record_tag    <= rdata_q.tag;
      out_q.last_result       <= status_o.i_at_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/two_key_record_sorter_unit.sv
// ----------------------------------------------------------------------------
// two_key_record_sorter_unit: top level of the two-key record sorter
// Collects a set of records, exchange-sorts them on primary then secondary
// key and emits them in order with the final one marked.
// ----------------------------------------------------------------------------
// A set is loaded at one item per cycle; up to 64 records are kept and any
// beyond that are dropped, though an item marked last still ends the set.
// While the set is sorted and emitted the input is stalled. The sort makes
// one key comparison a cycle on a record memory with one read and one write
// port, and emission then moves each record read from the store into the
// output register in turn, held back by any output stall. Once the final
// record sits in the output register the next set can start loading. The
// order bit is written through the configuration channel, which is always
// ready, and should change only between sets.
module two_key_record_sorter_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tks_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tks_pkg::out_item_t  out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  tks_pkg::cmd_t    cmd;
  tks_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  tks_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_item_i.last_item),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // Store, comparator and output register
  tks_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
